// ===== hw/rtl/tcpu_pkg.sv =====
// Package for the tiny CPU instruction execute block.
// Holds the opcode codes, the register file constants and the request and
// response transaction types. It depends on nothing else.
package tcpu_pkg;

   localparam int REG_COUNT      = 16;
   localparam int REG_ADDR_WIDTH = 4;

   typedef enum logic [7:0] {
      OP_INC   = 8'h01,
      OP_DEC   = 8'h02,
      OP_MOV   = 8'h03,
      OP_LDI   = 8'h04,
      OP_SHL   = 8'h05,
      OP_SAR   = 8'h06,
      OP_JMP   = 8'h07,
      OP_JZ    = 8'h08,
      OP_JNZ   = 8'h09,
      OP_JEOF  = 8'h0A,
      OP_HALT  = 8'h0B,
      OP_ADD   = 8'h0C,
      OP_SUB   = 8'h0D,
      OP_XOR   = 8'h0E,
      OP_OR    = 8'h0F,
      OP_READ  = 8'h10,
      OP_WRITE = 8'h11
   } opcode_type;

   typedef struct packed {
      logic [7:0] opcode;
      logic [7:0] operand;
      logic [7:0] in_byte;
      logic       in_eof;
   } req_type;

   typedef struct packed {
      logic [7:0] next_pc;
      logic       out_valid;
      logic [7:0] out_byte;
      logic       halted;
      logic       illegal;
      logic       zero_out;
   } rsp_type;

endpackage

// ===== hw/rtl/tiny_cpu_instruction_execute.sv =====
// Top level of the tiny CPU instruction execute block.
// Holds the register file, the program counter, the flags and the execute logic.
// Depends on tcpu_pkg for the opcode codes and the transaction types.
//
// Usage:
// Each request transaction carries one two-byte instruction (opcode and
// operand) together with the next input byte and its end-of-input mark.
// Each instruction yields exactly one response transaction with the next
// program counter, the output byte if any, and the halt, illegal and zero
// status. Both channels use valid and ready.
// A request is first captured in an input register, where both register
// file operands are read; the instruction executes on its way into the
// response register. One instruction is accepted in every cycle while the
// receiver takes each response, since the register file reads forward
// the value written by the instruction ahead. When the receiver stalls,
// the response register holds, the input register fills, and the request
// side then stalls as well.
// Reset clears all registers of the machine, the program counter and the
// flags, and empties both pipeline registers. After halt or an illegal
// opcode, further instructions are answered with the held program counter.
module tiny_cpu_instruction_execute
   import tcpu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic [7:0]           mem_ff [REG_COUNT];
   logic [REG_COUNT-1:0] reg_valid_ff;

   logic       in_valid_ff;
   req_type    in_data_ff;
   logic [7:0] d_data_ff;
   logic [7:0] s_data_ff;

   logic    out_valid_ff;
   rsp_type out_data_ff;
   rsp_type out_data_in;

   logic [7:0] pc_ff;
   logic [7:0] pc_in;
   logic       zero_ff;
   logic       zero_in;
   logic       eof_ff;
   logic       eof_in;
   logic       halt_ff;
   logic       halt_in;

   logic                      fire;
   logic                      req_fire;
   logic                      wr_en;
   logic [REG_ADDR_WIDTH-1:0] wr_addr;
   logic [7:0]                wr_data;
   logic [REG_ADDR_WIDTH-1:0] d_addr;
   logic [REG_ADDR_WIDTH-1:0] req_d_addr;
   logic [REG_ADDR_WIDTH-1:0] req_s_addr;
   logic [7:0]                alu_value;
   logic                      alu_used;
   logic [7:0]                jump_target;

   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign d_addr     = in_data_ff.operand[REG_ADDR_WIDTH-1:0];
   assign req_d_addr = req_data.operand[REG_ADDR_WIDTH-1:0];
   assign req_s_addr = req_data.operand[7:4];
   assign jump_target = pc_ff + in_data_ff.operand;

   always_comb begin
      pc_in       = pc_ff + 8'd2;
      zero_in     = zero_ff;
      eof_in      = eof_ff;
      halt_in     = halt_ff;
      wr_en       = 1'b0;
      wr_addr     = d_addr;
      wr_data     = d_data_ff;
      alu_value   = 8'd0;
      alu_used    = 1'b0;
      out_data_in = '0;
      if (halt_ff) begin
         pc_in = pc_ff;
      end else begin
         case (in_data_ff.opcode)
            OP_INC: begin
               alu_value = d_data_ff + 8'd1;
               alu_used  = 1'b1;
            end
            OP_DEC: begin
               alu_value = d_data_ff - 8'd1;
               alu_used  = 1'b1;
            end
            OP_MOV: begin
               wr_en   = 1'b1;
               wr_data = s_data_ff;
            end
            OP_LDI: begin
               wr_en   = 1'b1;
               wr_addr = '0;
               wr_data = in_data_ff.operand;
            end
            OP_SHL: begin
               alu_value = {d_data_ff[6:0], 1'b0};
               alu_used  = 1'b1;
            end
            OP_SAR: begin
               alu_value = {d_data_ff[7], d_data_ff[7:1]};
               alu_used  = 1'b1;
            end
            OP_JMP: begin
               pc_in = jump_target;
            end
            OP_JZ: begin
               if (zero_ff) begin
                  pc_in = jump_target;
               end
            end
            OP_JNZ: begin
               if (!zero_ff) begin
                  pc_in = jump_target;
               end
            end
            OP_JEOF: begin
               if (eof_ff) begin
                  pc_in = jump_target;
               end
            end
            OP_HALT: begin
               halt_in = 1'b1;
               pc_in   = pc_ff;
            end
            OP_ADD: begin
               alu_value = d_data_ff + s_data_ff;
               alu_used  = 1'b1;
            end
            OP_SUB: begin
               alu_value = d_data_ff - s_data_ff;
               alu_used  = 1'b1;
            end
            OP_XOR: begin
               alu_value = d_data_ff ^ s_data_ff;
               alu_used  = 1'b1;
            end
            OP_OR: begin
               alu_value = d_data_ff | s_data_ff;
               alu_used  = 1'b1;
            end
            OP_READ: begin
               if (in_data_ff.in_eof) begin
                  eof_in = 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  wr_data = in_data_ff.in_byte;
               end
            end
            OP_WRITE: begin
               out_data_in.out_valid = 1'b1;
               out_data_in.out_byte  = d_data_ff;
            end
            default: begin
               out_data_in.illegal = 1'b1;
               halt_in             = 1'b1;
               pc_in               = pc_ff;
            end
         endcase
         if (alu_used) begin
            wr_en   = 1'b1;
            wr_data = alu_value;
            zero_in = (alu_value == 8'd0);
         end
      end
      out_data_in.next_pc  = pc_in;
      out_data_in.halted   = halt_in;
      out_data_in.zero_out = zero_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pc_ff        <= '0;
         zero_ff      <= 1'b0;
         eof_ff       <= 1'b0;
         halt_ff      <= 1'b0;
         reg_valid_ff <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (fire) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (fire) begin
            pc_ff   <= pc_in;
            zero_ff <= zero_in;
            eof_ff  <= eof_in;
            halt_ff <= halt_in;
            if (wr_en && !halt_ff) begin
               reg_valid_ff[wr_addr] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && wr_en && !halt_ff) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_data;
         if (fire && wr_en && !halt_ff && (wr_addr == req_d_addr)) begin
            d_data_ff <= wr_data;
         end else if (!reg_valid_ff[req_d_addr]) begin
            d_data_ff <= 8'd0;
         end else begin
            d_data_ff <= mem_ff[req_d_addr];
         end
         if (fire && wr_en && !halt_ff && (wr_addr == req_s_addr)) begin
            s_data_ff <= wr_data;
         end else if (!reg_valid_ff[req_s_addr]) begin
            s_data_ff <= 8'd0;
         end else begin
            s_data_ff <= mem_ff[req_s_addr];
         end
      end
      if (fire) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the tiny CPU instruction execute block.
// Drives instruction transactions, predicts every response and compares each field.
// Depends on tcpu_pkg and tiny_cpu_instruction_execute.
module tb;
   import tcpu_pkg::*;

   localparam logic [7:0] ZERO_OPCODE = 8'h00;

   logic    clock;
   logic    reset;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type    instr_queue[$];
   rsp_type    expected_rsp[$];
   logic [7:0] cpu_regs[REG_COUNT];
   logic [7:0] cpu_pc;
   logic       cpu_zero;
   logic       cpu_eof;
   logic       cpu_halt;
   int         mismatch_count = 0;
   int         instr_count    = 0;
   int         rsp_count      = 0;
   int         taken_count    = 0;
   int         write_count    = 0;
   int         req_wait       = 0;
   int         rsp_wait       = 0;
   bit         req_idle_on    = 1'b0;
   bit         rsp_idle_on    = 1'b0;

   tiny_cpu_instruction_execute u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic req_type make_instr(logic [7:0] op, logic [7:0] arg,
                                          logic [7:0] in_byte = 8'h00,
                                          logic in_eof = 1'b0);
      req_type instr;
      instr.opcode  = op;
      instr.operand = arg;
      instr.in_byte = in_byte;
      instr.in_eof  = in_eof;
      return instr;
   endfunction

   function automatic rsp_type execute_instruction(req_type instr);
      rsp_type    result;
      logic [3:0] dst;
      logic [3:0] src;
      logic [7:0] alu;
      logic [7:0] target;
      logic       alu_op;
      result         = '0;
      dst            = instr.operand[3:0];
      src            = instr.operand[7:4];
      target         = cpu_pc + instr.operand;
      result.next_pc = cpu_pc + 8'd2;
      alu            = '0;
      alu_op         = 1'b0;
      if (cpu_halt) begin
         result.next_pc = cpu_pc;
      end else begin
         case (instr.opcode)
            OP_INC: begin
               alu    = cpu_regs[dst] + 8'd1;
               alu_op = 1'b1;
            end
            OP_DEC: begin
               alu    = cpu_regs[dst] - 8'd1;
               alu_op = 1'b1;
            end
            OP_MOV: cpu_regs[dst] = cpu_regs[src];
            OP_LDI: cpu_regs[0] = instr.operand;
            OP_SHL: begin
               alu    = {cpu_regs[dst][6:0], 1'b0};
               alu_op = 1'b1;
            end
            OP_SAR: begin
               alu    = {cpu_regs[dst][7], cpu_regs[dst][7:1]};
               alu_op = 1'b1;
            end
            OP_JMP: result.next_pc = target;
            OP_JZ: if (cpu_zero) result.next_pc = target;
            OP_JNZ: if (!cpu_zero) result.next_pc = target;
            OP_JEOF: if (cpu_eof) result.next_pc = target;
            OP_HALT: begin
               cpu_halt       = 1'b1;
               result.next_pc = cpu_pc;
            end
            OP_ADD: begin
               alu    = cpu_regs[dst] + cpu_regs[src];
               alu_op = 1'b1;
            end
            OP_SUB: begin
               alu    = cpu_regs[dst] - cpu_regs[src];
               alu_op = 1'b1;
            end
            OP_XOR: begin
               alu    = cpu_regs[dst] ^ cpu_regs[src];
               alu_op = 1'b1;
            end
            OP_OR: begin
               alu    = cpu_regs[dst] | cpu_regs[src];
               alu_op = 1'b1;
            end
            OP_READ: begin
               if (instr.in_eof) cpu_eof = 1'b1;
               else cpu_regs[dst] = instr.in_byte;
            end
            OP_WRITE: begin
               result.out_valid = 1'b1;
               result.out_byte  = cpu_regs[dst];
            end
            default: begin
               result.illegal = 1'b1;
               cpu_halt       = 1'b1;
               result.next_pc = cpu_pc;
            end
         endcase
         if (alu_op) begin
            cpu_regs[dst] = alu;
            cpu_zero      = (alu == 8'd0);
         end
         cpu_pc = result.next_pc;
      end
      result.halted   = cpu_halt;
      result.zero_out = cpu_zero;
      return result;
   endfunction

   task automatic compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      logic       next_valid;
      req_type    next_data;
      rsp_type    predicted;
      logic [7:0] old_pc;
      if (reset) begin
         req_valid <= 1'b0;
         req_wait = 0;
         foreach (cpu_regs[i]) cpu_regs[i] = '0;
         cpu_pc   = '0;
         cpu_zero = 1'b0;
         cpu_eof  = 1'b0;
         cpu_halt = 1'b0;
      end else begin
         next_valid = req_valid;
         next_data  = req_data;
         if (req_valid && req_ready) begin
            old_pc    = cpu_pc;
            predicted = execute_instruction(req_data);
            expected_rsp.push_back(predicted);
            if (!predicted.halted && predicted.next_pc != old_pc + 8'd2) taken_count++;
            if (predicted.out_valid) write_count++;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (req_wait > 0) begin
               req_wait--;
            end else if (instr_queue.size() != 0) begin
               next_data  = instr_queue.pop_front();
               next_valid = 1'b1;
               instr_count++;
               if (instr_count % 32 == 0) req_idle_on = ($urandom_range(0, 3) != 0);
               req_wait = req_idle_on ? $urandom_range(0, 14) : 0;
            end
         end
         req_valid <= next_valid;
         req_data  <= next_data;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (rsp_count % 32 == 0) rsp_idle_on = ($urandom_range(0, 3) != 0);
            rsp_wait = rsp_idle_on ? $urandom_range(0, 14) : 0;
            if (expected_rsp.size() == 0) begin
               $display("%0t ns: unexpected transaction, expected none, actual 0x%0h",
                        $time, rsp_data);
               mismatch_count++;
            end else begin
               want = expected_rsp.pop_front();
               compare_field("next_pc", 32'(want.next_pc), 32'(rsp_data.next_pc));
               compare_field("out_valid", 32'(want.out_valid), 32'(rsp_data.out_valid));
               compare_field("out_byte", 32'(want.out_byte), 32'(rsp_data.out_byte));
               compare_field("halted", 32'(want.halted), 32'(rsp_data.halted));
               compare_field("illegal", 32'(want.illegal), 32'(rsp_data.illegal));
               compare_field("zero_out", 32'(want.zero_out), 32'(rsp_data.zero_out));
            end
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [7:0] op;
      logic [7:0] arg;
      reset = 1'b1;

      instr_queue.push_back(make_instr(OP_LDI, 8'hFF));
      instr_queue.push_back(make_instr(OP_INC, 8'h00));
      instr_queue.push_back(make_instr(OP_JZ, 8'h04));
      instr_queue.push_back(make_instr(OP_DEC, 8'h00));
      instr_queue.push_back(make_instr(OP_JZ, 8'h10));
      instr_queue.push_back(make_instr(OP_JNZ, 8'h80));
      instr_queue.push_back(make_instr(OP_JEOF, 8'h06));
      instr_queue.push_back(make_instr(OP_MOV, 8'h0F));
      instr_queue.push_back(make_instr(OP_SHL, 8'h0F));
      instr_queue.push_back(make_instr(OP_SAR, 8'h0F));
      instr_queue.push_back(make_instr(OP_LDI, 8'h80));
      instr_queue.push_back(make_instr(OP_SHL, 8'h00));
      instr_queue.push_back(make_instr(OP_LDI, 8'h80));
      instr_queue.push_back(make_instr(OP_SAR, 8'h00));
      instr_queue.push_back(make_instr(OP_ADD, 8'hF1));
      instr_queue.push_back(make_instr(OP_SUB, 8'hFF));
      instr_queue.push_back(make_instr(OP_JNZ, 8'h22));
      instr_queue.push_back(make_instr(OP_JZ, 8'h7F));
      instr_queue.push_back(make_instr(OP_XOR, 8'h01));
      instr_queue.push_back(make_instr(OP_OR, 8'hF2));
      instr_queue.push_back(make_instr(OP_READ, 8'h03, 8'hA5, 1'b0));
      instr_queue.push_back(make_instr(OP_WRITE, 8'h03));
      instr_queue.push_back(make_instr(OP_READ, 8'h03, 8'h5A, 1'b1));
      instr_queue.push_back(make_instr(OP_JEOF, 8'hFE));
      instr_queue.push_back(make_instr(OP_WRITE, 8'h03));
      instr_queue.push_back(make_instr(OP_JMP, 8'h00));

      for (int k = 0; k < 500; k++) begin
         do op = 8'($urandom_range(OP_WRITE, OP_INC)); while (op == OP_HALT);
         arg = 8'($urandom);
         if ($urandom_range(0, 3) == 0) arg[7:4] = arg[3:0];
         instr_queue.push_back(make_instr(op, arg, 8'($urandom),
                                          ($urandom_range(0, 7) == 0)));
      end

      if ($urandom_range(0, 1) == 0) begin
         op = OP_HALT;
      end else if ($urandom_range(0, 3) == 0) begin
         op = ZERO_OPCODE;
      end else begin
         op = 8'($urandom_range(255, OP_WRITE + 1));
      end
      instr_queue.push_back(make_instr(op, 8'($urandom), 8'($urandom),
                                       1'($urandom_range(0, 1))));
      instr_queue.push_back(make_instr(8'hFF, 8'hFF, 8'hFF, 1'b1));
      instr_queue.push_back(make_instr(ZERO_OPCODE, 8'h00, 8'h00, 1'b0));
      instr_queue.push_back(make_instr(OP_HALT, 8'($urandom), 8'($urandom), 1'b0));
      instr_queue.push_back(make_instr(OP_JMP, 8'($urandom), 8'($urandom), 1'b1));
      for (int k = 0; k < 16; k++) begin
         instr_queue.push_back(make_instr(8'($urandom), 8'($urandom), 8'($urandom),
                                          1'($urandom_range(0, 1))));
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (instr_queue.size() != 0 || req_valid || expected_rsp.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);

      $display("Executed %0d instructions and checked %0d responses.", instr_count, rsp_count);
      $display("Taken branches: %0d, bytes written: %0d, final halt state: %0b.",
               taken_count, write_count, cpu_halt);
      if (mismatch_count == 0) begin
         $display("** tiny_cpu_instruction_execute: PASSED **");
      end else begin
         $display("** tiny_cpu_instruction_execute: FAILED **");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("Timed out with %0d transactions still expected.", expected_rsp.size());
      $display("** tiny_cpu_instruction_execute: FAILED **");
      $finish;
   end

endmodule
